### rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define PFM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/pfm_pkg.sv
// shared types and constants for the polynomial fractal membership block
`timescale 1ns / 1ps
package pfm_pkg;
  localparam int MaxDegreeDefault = 4;
  localparam int NumRegs = 8;
  localparam int FracBits = 28;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegCoeff4 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoeff3 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoeff2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoeff1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoeff0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCFlags = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRadius = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMaxIter = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BOUND, ST_CHECK, ST_COEF, ST_MUL, ST_ADD, ST_FINAL, ST_DONE
  } pfm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture c, z = c
    logic bound;     // form bound from |c|^2 and the radius, whichever is larger
    logic coef_top;  // acc = coefficient of top power
    logic mul_start; // begin complex multiply acc * z
    logic add;       // acc = product + coefficient
    logic commit;    // z = acc
  } pfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_bound;  // |z|^2 < bound
    logic mul_done;
    logic sat;       // saturation accumulated since the top coefficient of this step
  } pfm_status_t;
endpackage

### rtl/core/pfm_datapath.sv
// complex arithmetic datapath: shared multiplier, horner accumulator, magnitude test
`timescale 1ns / 1ps
module pfm_datapath #(
  parameter int MAX_DEGREE = pfm_pkg::MaxDegreeDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [31:0]   c_real,
  input  logic signed [31:0]   c_imag,
  input  logic [63:0]          coeff [MAX_DEGREE+1],
  input  logic [4:0]           c_flags,
  input  logic [35:0]          radius_sq,
  input  logic [$clog2(MAX_DEGREE+1)-1:0] power,
  input  pfm_pkg::pfm_cmd_t    cmd,
  output pfm_pkg::pfm_status_t status
);
  localparam int FracBitsL = pfm_pkg::FracBits;

  logic signed [31:0] cr, ci, zr, zi, accr, acci;
  logic [35:0] bound;
  logic sat;

  // effective coefficient of the selected power
  logic signed [32:0] ar, ai;
  always_comb begin
    ar = 33'(signed'(coeff[power][31:0]));
    ai = 33'(signed'(coeff[power][63:32]));
    if (c_flags[power]) begin
      ar = ar + 33'(cr);
      ai = ai + 33'(ci);
    end
  end

  function automatic logic fits(input logic signed [65:0] v);
    return (v >= -66'sd2147483648) && (v <= 66'sd2147483647);
  endfunction

  // two squarers on z feed the bound compare
  logic signed [63:0] sq_r, sq_i;
  logic [63:0] mag_sum;
  logic [35:0] mag;
  assign sq_r = zr * zr;
  assign sq_i = zi * zi;
  assign mag_sum = sq_r + sq_i;
  assign mag = mag_sum[63:FracBitsL];

  // shared multiplier, forms the four products in turn
  logic [1:0] mstep;
  logic mbusy;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [65:0] re_sum, im_sum;
  always_comb begin
    unique case (mstep)
      2'd0: begin ma = accr; mb = zr; end
      2'd1: begin ma = acci; mb = zi; end
      2'd2: begin ma = accr; mb = zi; end
      default: begin ma = acci; mb = zr; end
    endcase
  end
  assign prod = ma * mb;

  logic signed [63:0] prod_q;
  logic prod_v;
  logic [1:0] prod_step;
  logic mul_done;

  logic signed [65:0] re_sh, im_sh;
  assign re_sh = re_sum >>> FracBitsL;
  assign im_sh = im_sum >>> FracBitsL;

  logic signed [33:0] sumr, sumi;
  assign sumr = 34'(signed'(re_sh[31:0])) + 34'(ar);
  assign sumi = 34'(signed'(im_sh[31:0])) + 34'(ai);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      prod_v <= 1'b0;
      mul_done <= 1'b0;
      mstep <= '0;
    end else begin
      mul_done <= 1'b0;
      prod_v <= mbusy;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mstep <= '0;
      end else if (mbusy) begin
        mstep <= mstep + 2'd1;
        if (mstep == 2'd3) mbusy <= 1'b0;
      end
      if (prod_v && prod_step == 2'd3) mul_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= prod;
    prod_step <= mstep;
    if (prod_v) begin
      unique case (prod_step)
        2'd0: re_sum <= 66'(prod_q);
        2'd1: re_sum <= re_sum - 66'(prod_q);
        2'd2: im_sum <= 66'(prod_q);
        default: im_sum <= im_sum + 66'(prod_q);
      endcase
    end
    if (cmd.load) begin
      cr <= c_real; ci <= c_imag; zr <= c_real; zi <= c_imag;
    end
    if (cmd.bound) bound <= (radius_sq > mag) ? radius_sq : mag;
    if (cmd.coef_top) begin
      accr <= ar[31:0]; acci <= ai[31:0];
      sat <= !fits(66'(ar)) || !fits(66'(ai));
    end
    // saturation of the top coefficient carries through the whole step
    if (cmd.add) begin
      accr <= sumr[31:0]; acci <= sumi[31:0];
      sat <= sat || !fits(re_sh) || !fits(im_sh) || !fits(66'(ar)) || !fits(66'(ai))
             || !fits(66'(sumr)) || !fits(66'(sumi));
    end
    if (cmd.commit) begin
      zr <= accr; zi <= acci;
    end
  end

  assign status.in_bound = mag < bound;
  assign status.mul_done = mul_done;
  assign status.sat = sat;
endmodule

### rtl/core/pfm_ctrl.sv
// iteration controller for the fractal membership test
`timescale 1ns / 1ps
module pfm_ctrl #(
  parameter int MAX_DEGREE = pfm_pkg::MaxDegreeDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 in_set,
  input  logic [15:0]          max_iterations,
  input  pfm_pkg::pfm_status_t status,
  output pfm_pkg::pfm_cmd_t    cmd,
  output logic [$clog2(MAX_DEGREE+1)-1:0] power
);
  localparam int PW = $clog2(MAX_DEGREE + 1);
  pfm_pkg::pfm_state_t state, state_next;
  logic [15:0] iter;
  logic result;

  always_comb begin
    state_next = state;
    unique case (state)
      pfm_pkg::ST_IDLE:  if (in_valid) state_next = pfm_pkg::ST_BOUND;
      pfm_pkg::ST_BOUND: state_next = pfm_pkg::ST_CHECK;
      pfm_pkg::ST_CHECK:
        if (iter == max_iterations || !status.in_bound) state_next = pfm_pkg::ST_DONE;
        else state_next = pfm_pkg::ST_COEF;
      pfm_pkg::ST_COEF:  state_next = pfm_pkg::ST_MUL;
      pfm_pkg::ST_MUL:   if (status.mul_done) state_next = pfm_pkg::ST_ADD;
      pfm_pkg::ST_ADD:   state_next = pfm_pkg::ST_FINAL;
      pfm_pkg::ST_FINAL:
        if (status.sat) state_next = pfm_pkg::ST_DONE;
        else if (power == '0) state_next = pfm_pkg::ST_CHECK;
        else state_next = pfm_pkg::ST_MUL;
      pfm_pkg::ST_DONE:  if (out_ready) state_next = pfm_pkg::ST_IDLE;
      default: state_next = pfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == pfm_pkg::ST_IDLE) && in_valid;
    cmd.bound = (state == pfm_pkg::ST_BOUND);
    cmd.coef_top = (state == pfm_pkg::ST_COEF);
    cmd.mul_start = (state == pfm_pkg::ST_COEF) ||
                    (state == pfm_pkg::ST_FINAL && !status.sat && power != '0);
    cmd.add = (state == pfm_pkg::ST_MUL) && status.mul_done;
    cmd.commit = (state == pfm_pkg::ST_FINAL) && !status.sat && power == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfm_pkg::ST_IDLE;
      iter <= '0;
      power <= '0;
      result <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        pfm_pkg::ST_IDLE: iter <= '0;
        pfm_pkg::ST_CHECK: begin
          result <= status.in_bound;
          power <= PW'(MAX_DEGREE);
        end
        pfm_pkg::ST_COEF: power <= power - PW'(1);
        pfm_pkg::ST_FINAL: begin
          if (status.sat) result <= 1'b0;
          else if (power == '0) iter <= iter + 16'd1;
          else power <= power - PW'(1);
        end
        default: ;
      endcase
    end
  end

  assign in_ready = (state == pfm_pkg::ST_IDLE);
  assign out_valid = (state == pfm_pkg::ST_DONE);
  assign in_set = result;
endmodule

### rtl/core/polynomial_fractal_membership.sv
// top level of the polynomial fractal membership block
`timescale 1ns / 1ps
// each transaction is paced by the shared complex multiplier, which forms the four
// products one per cycle; the block takes one transaction at a time, and a new input is
// taken only once the result of the last one has been accepted
// reset (rst, synchronous): registers return to the classic z^2 + c set
module polynomial_fractal_membership #(
  parameter int MAX_DEGREE = pfm_pkg::MaxDegreeDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   c_real,
  input  logic signed [31:0]   c_imag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 in_set,
  input  logic                 cfg_we,
  input  logic [pfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pfm_pkg::CfgDataW-1:0] cfg_data
);
  // coefficient registers indexed by power
  logic [63:0] coeff [MAX_DEGREE+1];
  logic [63:0] coeff_all [5];
  logic [4:0]  c_flags;
  logic [35:0] radius_sq;
  logic [15:0] max_iterations;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_all[0] <= '0;
      coeff_all[1] <= '0;
      coeff_all[2] <= 64'd268435456;
      coeff_all[3] <= '0;
      coeff_all[4] <= '0;
      c_flags <= 5'd1;
      radius_sq <= 36'd1073741824;
      max_iterations <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfm_pkg::RegCoeff4:  coeff_all[4] <= cfg_data;
        pfm_pkg::RegCoeff3:  coeff_all[3] <= cfg_data;
        pfm_pkg::RegCoeff2:  coeff_all[2] <= cfg_data;
        pfm_pkg::RegCoeff1:  coeff_all[1] <= cfg_data;
        pfm_pkg::RegCoeff0:  coeff_all[0] <= cfg_data;
        pfm_pkg::RegCFlags:  c_flags <= cfg_data[4:0];
        pfm_pkg::RegRadius:  radius_sq <= cfg_data[35:0];
        pfm_pkg::RegMaxIter: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // only powers up to MAX_DEGREE take part
  always_comb begin
    for (int k = 0; k <= MAX_DEGREE; k++) coeff[k] = coeff_all[k];
  end

  pfm_pkg::pfm_cmd_t    cmd;
  pfm_pkg::pfm_status_t status;
  logic [$clog2(MAX_DEGREE+1)-1:0] power;

  pfm_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .in_set,
    .max_iterations, .status, .cmd, .power
  );

  pfm_datapath #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .rst, .c_real, .c_imag, .coeff, .c_flags, .radius_sq,
    .power, .cmd, .status
  );
endmodule

### rtl/core/pfm_checker.sv
// port-level checker for the fractal membership block
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic in_set
);
  `PFM_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `PFM_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `PFM_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(in_set), "result dropped")
endmodule

bind polynomial_fractal_membership pfm_checker u_pfm_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .in_set
);

### sim/polynomial_fractal_membership_tb.sv
// self-checking testbench for the polynomial fractal membership block
`timescale 1ns / 1ps
module polynomial_fractal_membership_tb;

  localparam int MAX_DEGREE = 4;
  localparam logic signed [31:0] FX_ONE = 32'sh1000_0000;   // 1.0 in Q4.28
  localparam logic signed [31:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;
  localparam int N_RANDOM = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   c_real = '0;
  logic signed [31:0]   c_imag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 in_set;
  logic                 cfg_we = 1'b0;
  logic [pfm_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pfm_pkg::CfgDataW-1:0] cfg_data = '0;

  polynomial_fractal_membership #(.MAX_DEGREE(MAX_DEGREE)) dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("[polynomial_fractal_membership] ERROR");
    $finish;
  end

  // shadow copy of the register file, indexed by power
  logic [63:0] coef_by_pow [MAX_DEGREE+1];
  logic [4:0]  flag_bits;
  logic [35:0] bound_floor;
  logic [15:0] iter_limit;

  // expected membership verdicts, oldest first
  bit          verdict_q [$];
  int          n_sent = 0, n_got = 0, n_inside = 0, n_mismatch = 0;
  bit          pressure_done = 1'b0;

  // ---------------- escape-time predictor ----------------

  function automatic bit fits_q4_28(input logic signed [65:0] v);
    return v >= -66'sd2147483648 && v <= 66'sd2147483647;
  endfunction

  function automatic logic [35:0] mag_sq(input longint re, input longint im);
    logic [63:0] s;
    s = longint'(re * re) + longint'(im * im);
    return s[63:28];
  endfunction

  // complex product, floor-rounded back to Q4.28; 0 on saturation
  function automatic bit cplx_mul(input longint ar, ai, br, bi,
                                  output longint rr, ri);
    logic signed [65:0] re, im;
    re = 66'(ar * br) - 66'(ai * bi);
    im = 66'(ar * bi) + 66'(ai * br);
    re = re >>> pfm_pkg::FracBits;
    im = im >>> pfm_pkg::FracBits;
    if (!fits_q4_28(re) || !fits_q4_28(im)) return 1'b0;
    rr = longint'(re);
    ri = longint'(im);
    return 1'b1;
  endfunction

  // coefficient of one power, with c folded in when its flag is set
  function automatic bit power_coef(input int k, input longint cr, ci,
                                    output longint ar, ai);
    logic signed [65:0] re, im;
    re = 66'(signed'(coef_by_pow[k][31:0]));
    im = 66'(signed'(coef_by_pow[k][63:32]));
    if (flag_bits[k]) begin
      re = re + cr;
      im = im + ci;
    end
    if (!fits_q4_28(re) || !fits_q4_28(im)) return 1'b0;
    ar = longint'(re);
    ai = longint'(im);
    return 1'b1;
  endfunction

  function automatic bit predict_in_set(input logic signed [31:0] cr32, ci32);
    longint cr, ci, zr, zi, accr, acci, ar, ai;
    logic [35:0] bnd;
    logic signed [65:0] sr, si;
    cr = cr32;
    ci = ci32;
    zr = cr;
    zi = ci;
    bnd = mag_sq(cr, ci);
    if (bound_floor > bnd) bnd = bound_floor;
    for (int i = 0; i < iter_limit && mag_sq(zr, zi) < bnd; i++) begin
      // horner from the top power down
      if (!power_coef(MAX_DEGREE, cr, ci, accr, acci)) return 1'b0;
      for (int k = MAX_DEGREE - 1; k >= 0; k--) begin
        if (!cplx_mul(accr, acci, zr, zi, accr, acci)) return 1'b0;
        if (!power_coef(k, cr, ci, ar, ai)) return 1'b0;
        sr = 66'(accr) + ar;
        si = 66'(acci) + ai;
        if (!fits_q4_28(sr) || !fits_q4_28(si)) return 1'b0;
        accr = longint'(sr);
        acci = longint'(si);
      end
      zr = accr;
      zi = acci;
    end
    return mag_sq(zr, zi) < bnd;
  endfunction

  // ---------------- register writes ----------------

  task automatic write_reg(input logic [pfm_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pfm_pkg::RegCoeff4:  coef_by_pow[4] = val;
      pfm_pkg::RegCoeff3:  coef_by_pow[3] = val;
      pfm_pkg::RegCoeff2:  coef_by_pow[2] = val;
      pfm_pkg::RegCoeff1:  coef_by_pow[1] = val;
      pfm_pkg::RegCoeff0:  coef_by_pow[0] = val;
      pfm_pkg::RegCFlags:  flag_bits = val[4:0];
      pfm_pkg::RegRadius:  bound_floor = val[35:0];
      pfm_pkg::RegMaxIter: iter_limit = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers change only once the block has drained
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // ---------------- input side ----------------

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // one input transaction; typed rows carry their own verdict
  task automatic send_point(input logic signed [31:0] cr, ci,
                            input bit typed, input bit typed_val);
    @(negedge clk);
    in_valid <= 1'b1;
    c_real <= cr;
    c_imag <= ci;
    do @(posedge clk); while (!in_ready);
    verdict_q.insert(verdict_q.size(), typed ? typed_val : predict_in_set(cr, ci));
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? FX_MAX : FX_MIN;
      3, 4:    return $urandom_range(0, 32'h1000_0000) - 32'sh0800_0000;
      default: return $urandom_range(0, 32'h4000_0000) - 32'sh2000_0000;
    endcase
  endfunction

  function automatic logic [63:0] rand_coef();
    logic [31:0] re, im;
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return {$urandom(), $urandom()};
      2:       return $urandom_range(0, 1) ? 64'hffff_ffff_ffff_ffff : 64'h7fff_ffff_8000_0000;
      default: begin
        re = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        im = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        return {im, re};
      end
    endcase
  endfunction

  task automatic random_setting();
    logic [63:0] c2;
    write_reg(pfm_pkg::RegCoeff4, ($urandom_range(0, 2) == 0) ? rand_coef() : 64'd0);
    write_reg(pfm_pkg::RegCoeff3, ($urandom_range(0, 2) == 0) ? rand_coef() : 64'd0);
    c2 = ($urandom_range(0, 1) == 0) ? 64'(FX_ONE) : rand_coef();
    write_reg(pfm_pkg::RegCoeff2, c2);
    write_reg(pfm_pkg::RegCoeff1, rand_coef());
    write_reg(pfm_pkg::RegCoeff0, rand_coef());
    case ($urandom_range(0, 4))
      0:       write_reg(pfm_pkg::RegCFlags, 64'd0);
      1:       write_reg(pfm_pkg::RegCFlags, 64'd31);
      default: write_reg(pfm_pkg::RegCFlags, 64'($urandom_range(0, 31)));
    endcase
    case ($urandom_range(0, 5))
      0:       write_reg(pfm_pkg::RegRadius, 64'd0);
      1:       write_reg(pfm_pkg::RegRadius, 64'hf_ffff_ffff);
      2:       write_reg(pfm_pkg::RegRadius, {$urandom_range(0, 15), $urandom()});
      default: write_reg(pfm_pkg::RegRadius, 64'h4000_0000);
    endcase
    write_reg(pfm_pkg::RegMaxIter,
              ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom_range(1, 24)));
  endtask

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    bit                 typed;
    bit                 val;
  } point_row_t;

  // directed points on the classic z^2 + c setting after reset
  point_row_t directed [15] = '{
    '{32'sd0,          32'sd0,   1'b1, 1'b1},  // origin never moves
    '{FX_MAX,          FX_MAX,   1'b1, 1'b0},  // far corner, beyond radius
    '{FX_MIN,          FX_MIN,   1'b1, 1'b0},
    '{FX_MIN,          FX_MAX,   1'b1, 1'b0},
    '{-2 * FX_ONE,     32'sd0,   1'b1, 1'b0},  // |c|^2 exactly 4.0 fails at once
    '{32'sd0,          2 * FX_ONE, 1'b1, 1'b0},
    '{-FX_ONE,         32'sd0,   1'b0, 1'b0},  // period two orbit
    '{FX_ONE,          32'sd0,   1'b0, 1'b0},
    '{FX_ONE / 4,      32'sd0,   1'b0, 1'b0},  // cusp
    '{FX_ONE / 4 + 1,  32'sd0,   1'b0, 1'b0},
    '{32'sd0,          FX_ONE,   1'b0, 1'b0},
    '{-32'sh0c00_0000, 32'sd0,   1'b0, 1'b0},
    '{32'sd1,          -32'sd1,  1'b0, 1'b0},
    '{32'sh5555_5555,  32'shaaaa_aaaa, 1'b0, 1'b0},
    '{-FX_ONE / 2,     FX_ONE / 2, 1'b0, 1'b0}
  };

  // ---------------- output side ----------------

  int hold_left = 0;

  // receiver stalls; one long hold-off fills the block and stalls its input
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!pressure_done && n_sent >= 300) begin
      pressure_done <= 1'b1;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    end
  end

  // compare each result transaction with the oldest verdict
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_got++;
      if (verdict_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction, in_set=%0b", in_set);
      end else begin
        bit exp_v;
        exp_v = verdict_q.pop_front();
        if (in_set !== exp_v) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("in_set mismatch on result %0d: expected %0b got %0b", n_got, exp_v, in_set);
        end
        if (in_set === 1'b1) n_inside++;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    // reset values of the shadow registers
    for (int k = 0; k <= MAX_DEGREE; k++) coef_by_pow[k] = 64'd0;
    coef_by_pow[2] = 64'(FX_ONE);
    flag_bits = 5'd1;
    bound_floor = 36'h4000_0000;
    iter_limit = 16'd100;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_point(directed[i].re, directed[i].im, directed[i].typed, directed[i].val);
      idle_gap();
    end
    wait_drained();

    // longest iteration limit with zero radius: every orbit ends at once
    write_reg(pfm_pkg::RegRadius, 64'd0);
    write_reg(pfm_pkg::RegMaxIter, 64'hffff);
    write_reg(pfm_pkg::RegCoeff4, 64'hffff_ffff_ffff_ffff);
    write_reg(pfm_pkg::RegCFlags, 64'd31);
    for (int i = 0; i < 8; i++) begin
      send_point(rand_coord(), rand_coord(), 1'b0, 1'b0);
      idle_gap();
    end
    wait_drained();

    // random settings, each followed by a run of random points
    for (int ph = 0; ph < 10; ph++) begin
      random_setting();
      for (int i = 0; i < N_RANDOM / 10; i++) begin
        send_point(rand_coord(), rand_coord(), 1'b0, 1'b0);
        idle_gap();
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d points over 12 register settings, %0d inside the set",
             n_sent, n_inside);
    $display("results checked: %0d, mismatches: %0d, left over: %0d",
             n_got, n_mismatch, verdict_q.size());
    if (n_mismatch == 0 && verdict_q.size() == 0)
      $display("[polynomial_fractal_membership] OK");
    else
      $display("[polynomial_fractal_membership] ERROR");
    $finish;
  end

endmodule
